>>> hdl/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Clocked check, masked while reset is high.
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/spq_pkg.sv
// Package with types, codes and helpers for the sorted priority queue.
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ECNT_W   = 5;

   // operation codes
   localparam logic [1:0] FUNC_PUSH   = 2'd0;
   localparam logic [1:0] FUNC_POP    = 2'd1;
   localparam logic [1:0] FUNC_SEARCH = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

   // ordering modes: relation(stored, new)
   localparam logic [1:0] MODE_LE = 2'd0;
   localparam logic [1:0] MODE_GE = 2'd1;
   localparam logic [1:0] MODE_LT = 2'd2;
   localparam logic [1:0] MODE_GT = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] item_value;
      logic signed [31:0] item_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] popped_value;
      logic signed [31:0] popped_priority;
      logic               found;
      logic signed [31:0] head_value;
      logic signed [31:0] head_priority;
      logic               is_empty;
      logic [ECNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] prio;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [1:0] mode;
   } cell_ctl_type;

   // does the walk continue past a stored priority?
   function automatic logic relation_holds(input logic [1:0] mode,
                                           input logic signed [31:0] stored,
                                           input logic signed [31:0] incoming);
      logic r;
      begin
         unique case (mode)
            MODE_LE: r = stored <= incoming;
            MODE_GE: r = stored >= incoming;
            MODE_LT: r = stored < incoming;
            MODE_GT: r = stored > incoming;
            default: r = 1'b0;
         endcase
         return r;
      end
   endfunction

endpackage

>>> hdl/spq_cell.sv
// One storage cell of the queue chain: compare, hold, shift left or right.
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::entry_type    new_entry,
   input  logic                  occupied,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   input  logic                  stop_seen_in,
   output logic                  stop_seen_out,
   output logic                  hit,
   output spq_pkg::entry_type    entry,
   output spq_pkg::entry_type    entry_next
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;
   logic               identical;
   logic               stop_here;

   // local compare against the incoming pair
   assign identical = (entry_ff == new_entry);
   assign stop_here = !occupied ||
                      identical ||
                      !spq_pkg::relation_holds(ctl.mode, entry_ff.prio,
                                               new_entry.prio);
   assign stop_seen_out = stop_seen_in | stop_here;
   assign hit           = occupied & identical;

   // push: cells past the insert point shift right, the insert point loads
   // the new pair; pop: every cell takes its right neighbor
   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         if (stop_seen_in) begin
            entry_in = left_entry;
         end else if (stop_here) begin
            entry_in = new_entry;
         end
      end else if (ctl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

>>> hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, count, result register.
//
// Bounded priority queue of spq_pkg::CAPACITY entries held in a row of cells in
// sorted order. For every push, pop or search all cells compare against the
// incoming pair at once and, on a push or pop, shift in parallel, so a new
// item is taken every cycle while the result side is not stalled. The result
// appears in the output register the cycle after the item is accepted and the
// input keeps flowing while that result waits, until the output is stalled
// with a result still held. The mode register mode_ff is written through the csr
// channel, which is always ready; write it only while the queue is idle.
module sorted_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);

`include "sorted_priority_queue_assert.svh"

   localparam int N = spq_pkg::CAPACITY;

   logic [1:0]                mode_ff;
   logic [spq_pkg::CNT_W-1:0] fill_ff;
   logic [spq_pkg::CNT_W-1:0] fill_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   spq_pkg::rsp_type          rsp_ff;
   spq_pkg::rsp_type          rsp_in;

   logic                  req_xfer;
   logic                  is_push;
   logic                  is_pop;
   logic                  is_search;
   logic                  full;
   logic                  empty;
   spq_pkg::cell_ctl_type ctl;
   spq_pkg::entry_type    new_entry;
   spq_pkg::entry_type    cell_q    [N];
   spq_pkg::entry_type    cell_next [N];
   logic [N:0]            stop_chain;
   logic [N-1:0]          hit_vec;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= spq_pkg::MODE_LE;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   // input transfer and decode
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & !req_stall;
   assign is_push   = req_xfer && (req_data.func == spq_pkg::FUNC_PUSH);
   assign is_pop    = req_xfer && (req_data.func == spq_pkg::FUNC_POP);
   assign is_search = req_xfer && (req_data.func == spq_pkg::FUNC_SEARCH);
   assign full      = (fill_ff == spq_pkg::CNT_W'(N));
   assign empty     = (fill_ff == '0);

   assign ctl.push = is_push & !full;
   assign ctl.pop  = is_pop & !empty;
   assign ctl.mode = mode_ff;
   assign new_entry.value = req_data.item_value;
   assign new_entry.prio  = req_data.item_priority;

   // cell chain
   assign stop_chain[0] = 1'b0;
   for (genvar i = 0; i < N; i++) begin : g_cell
      spq_pkg::entry_type left_e;
      spq_pkg::entry_type right_e;
      logic               occ;

      assign occ = (spq_pkg::CNT_W'(i) < fill_ff);
      if (i == 0) begin : g_first
         assign left_e = new_entry;
      end else begin : g_mid_l
         assign left_e = cell_q[i-1];
      end
      if (i == N - 1) begin : g_last
         assign right_e = cell_q[i];
      end else begin : g_mid_r
         assign right_e = cell_q[i+1];
      end

      spq_cell u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .new_entry     (new_entry),
         .occupied      (occ),
         .left_entry    (left_e),
         .right_entry   (right_e),
         .stop_seen_in  (stop_chain[i]),
         .stop_seen_out (stop_chain[i+1]),
         .hit           (hit_vec[i]),
         .entry         (cell_q[i]),
         .entry_next    (cell_next[i])
      );
   end

   // entry count
   always_comb begin
      fill_in = fill_ff;
      if (ctl.push) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // result assembly
   always_comb begin
      rsp_in = '0;
      if (is_pop && empty) begin
         rsp_in.status = spq_pkg::STATUS_POP_EMPTY;
      end else if (is_push && full) begin
         rsp_in.status = spq_pkg::STATUS_PUSH_FULL;
      end else begin
         rsp_in.status = spq_pkg::STATUS_OK;
      end
      if (ctl.pop) begin
         rsp_in.popped_value    = cell_q[0].value;
         rsp_in.popped_priority = cell_q[0].prio;
      end
      rsp_in.found = is_search & (|hit_vec);
      if (fill_in != '0) begin
         rsp_in.head_value    = cell_next[0].value;
         rsp_in.head_priority = cell_next[0].prio;
      end
      rsp_in.is_empty    = (fill_in == '0);
      rsp_in.entry_count = spq_pkg::ECNT_W'(fill_in);
   end

   // output register
   assign rsp_valid_in = req_xfer | (rsp_valid_ff & rsp_stall);
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `SPQ_ASSERT_ALWAYS(a_fill_bound, clock, reset || (fill_ff <= spq_pkg::CNT_W'(N)), "fill count above capacity")
   `SPQ_ASSERT(a_push_grows, clock, reset, ctl.push |=> fill_ff == $past(fill_ff) + 1'b1, "push did not grow count")
   `SPQ_ASSERT(a_pop_empty, clock, reset, (is_pop && empty) |=> rsp_data.status == spq_pkg::STATUS_POP_EMPTY, "pop on empty not flagged")
   `SPQ_ASSERT(a_result_follows, clock, reset, req_xfer |=> rsp_valid_ff, "accepted item left no result")

endmodule
